// ===== rtl/range_min_max_tree_top_macros.svh =====
// Assertion helpers used by the RTL top level
`ifndef RANGE_MIN_MAX_TREE_TOP_MACROS_SVH
`define RANGE_MIN_MAX_TREE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define RMMT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RMMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rmmt_pkg.sv =====
`default_nettype none
package rmmt_pkg;

  localparam int VALUE_BITS      = 32;
  localparam int POS_BITS        = 10;
  localparam int CFG_BITS        = 11;
  localparam int DEF_MAX_ENTRIES = 1024;

  localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] VAL_NEG_ONE = {VALUE_BITS{1'b1}};

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic                         action;
    logic [POS_BITS-1:0]          position;
    logic signed [VALUE_BITS-1:0] new_value;
    logic [POS_BITS-1:0]          range_start;
    logic [POS_BITS-1:0]          range_end;
  } in_item_t;

  typedef struct packed {
    logic                         status;
    logic signed [VALUE_BITS-1:0] range_min;
    logic signed [VALUE_BITS-1:0] range_max;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_U_DESC,
    S_U_SIB,
    S_U_ASC,
    S_Q_VISIT,
    S_Q_ACC
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic desc_step;
    logic leaf_write;
    logic sib_read;
    logic asc_write;
    logic q_split;
    logic q_read;
    logic q_acc;
    logic q_pop;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic upd_ok;
    logic q_ok;
    logic cur_leaf;
    logic cur_root;
    logic parent_root;
    logic q_cover;
    logic q_disjoint;
    logic stack_empty;
    logic stack_full;
    logic out_blocked;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/rmmt_ram.sv =====
`default_nettype none
module rmmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/rmmt_ctrl.sv =====
`default_nettype none
module rmmt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output rmmt_pkg::cmd_t     cmd_o,
  input  wire rmmt_pkg::sts_t sts_i
);
  import rmmt_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.is_query) begin
          if (sts_i.q_ok) begin
            state_d = S_Q_VISIT;
          end else if (!sts_i.out_blocked) begin
            cmd_o.out_load = 1'b1;
            state_d        = S_IDLE;
          end
        end else if (sts_i.upd_ok) begin
          state_d = S_U_DESC;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_U_DESC: begin
        if (sts_i.cur_leaf) begin
          cmd_o.leaf_write = 1'b1;
          state_d = sts_i.cur_root ? S_IDLE : S_U_SIB;
        end else begin
          cmd_o.desc_step = 1'b1;
        end
      end
      S_U_SIB: begin
        cmd_o.sib_read = 1'b1;
        state_d        = S_U_ASC;
      end
      S_U_ASC: begin
        cmd_o.asc_write = 1'b1;
        state_d = sts_i.parent_root ? S_IDLE : S_U_SIB;
      end
      S_Q_VISIT: begin
        if (sts_i.q_cover) begin
          cmd_o.q_read = 1'b1;
          state_d      = S_Q_ACC;
        end else if (sts_i.q_disjoint || sts_i.cur_leaf) begin
          if (!sts_i.stack_empty) begin
            cmd_o.q_pop = 1'b1;
          end else if (!sts_i.out_blocked) begin
            cmd_o.out_load = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.q_split = 1'b1;
        end
      end
      S_Q_ACC: begin
        // fold the node once, then either continue or hold for the output
        if (!sts_i.stack_empty) begin
          cmd_o.q_acc = 1'b1;
          cmd_o.q_pop = 1'b1;
          state_d     = S_Q_VISIT;
        end else if (!sts_i.out_blocked) begin
          cmd_o.q_acc    = 1'b1;
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/rmmt_dp.sv =====
`default_nettype none
module rmmt_dp #(
  parameter int MAX_ENTRIES = rmmt_pkg::DEF_MAX_ENTRIES
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire rmmt_pkg::in_item_t                 in_data_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [rmmt_pkg::CFG_BITS-1:0]      cfg_wdata_i,
  input  wire logic                               out_stall_i,
  output logic                                    out_valid_o,
  output rmmt_pkg::out_item_t                     out_data_o,
  input  wire rmmt_pkg::cmd_t                     cmd_i,
  output rmmt_pkg::sts_t                          sts_o
);
  import rmmt_pkg::*;

  localparam int TREE_SLOTS = 4 * MAX_ENTRIES;
  localparam int NODE_BITS  = $clog2(TREE_SLOTS);
  localparam int IDX_BITS   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int N_BITS     = $clog2(MAX_ENTRIES + 1);
  localparam int STK_DEPTH  = IDX_BITS + 2;
  localparam int SP_BITS    = $clog2(STK_DEPTH + 1);
  localparam int SPI_BITS   = $clog2(STK_DEPTH);

  typedef struct packed {
    logic [NODE_BITS-1:0] node;
    logic [IDX_BITS-1:0]  lo;
    logic [IDX_BITS-1:0]  hi;
  } frame_t;

  logic [N_BITS-1:0]    n_q;
  in_item_t             item_q;
  frame_t               cur_q, cur_d;
  frame_t               stk_q [STK_DEPTH];
  logic [SP_BITS-1:0]   sp_q;
  logic [NODE_BITS-1:0] clr_q;
  logic signed [VALUE_BITS-1:0] acc_min_q, acc_max_q, acc_min_d, acc_max_d;
  logic                 out_valid_q;
  out_item_t            out_q;

  logic signed [VALUE_BITS-1:0] rd_min, rd_max, wd_min, wd_max;
  logic signed [VALUE_BITS-1:0] fold_min, fold_max;
  logic                 we;
  logic [NODE_BITS-1:0] waddr, raddr, parent, sibling, lchild, rchild;
  logic [IDX_BITS-1:0]  mid, hi_root;
  logic [SP_BITS-1:0]   sp_dec;

  // entry-count register, clamped to 1..MAX_ENTRIES
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= N_BITS'(MAX_ENTRIES);
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        n_q <= N_BITS'(1);
      end else if (32'(cfg_wdata_i) > 32'(MAX_ENTRIES)) begin
        n_q <= N_BITS'(MAX_ENTRIES);
      end else begin
        n_q <= N_BITS'(cfg_wdata_i);
      end
    end
  end

  // node arithmetic
  assign mid     = cur_q.lo + ((cur_q.hi - cur_q.lo) >> 1);
  assign lchild  = NODE_BITS'({cur_q.node, 1'b1});
  assign rchild  = NODE_BITS'(({1'b0, cur_q.node} << 1) + (NODE_BITS + 1)'(2));
  assign parent  = (cur_q.node - NODE_BITS'(1)) >> 1;
  assign sibling = cur_q.node[0] ? cur_q.node + NODE_BITS'(1)
                                 : cur_q.node - NODE_BITS'(1);
  assign hi_root = IDX_BITS'(n_q - N_BITS'(1));
  assign sp_dec  = sp_q - SP_BITS'(1);

  // combine against the node read last cycle
  assign fold_min = (rd_min < acc_min_q) ? rd_min : acc_min_q;
  assign fold_max = (rd_max > acc_max_q) ? rd_max : acc_max_q;

  // status toward the controller
  always_comb begin
    sts_o             = '0;
    sts_o.clr_last    = (clr_q == NODE_BITS'(TREE_SLOTS - 1));
    sts_o.is_query    = (item_q.action == ACT_QUERY);
    sts_o.upd_ok      = 32'(item_q.position) < 32'(n_q);
    sts_o.q_ok        = (item_q.range_start <= item_q.range_end) &&
                        (32'(item_q.range_end) < 32'(n_q));
    sts_o.cur_leaf    = (cur_q.lo == cur_q.hi);
    sts_o.cur_root    = (cur_q.node == '0);
    sts_o.parent_root = (parent == '0);
    sts_o.q_cover     = (32'(item_q.range_start) <= 32'(cur_q.lo)) &&
                        (32'(item_q.range_end) >= 32'(cur_q.hi));
    sts_o.q_disjoint  = (32'(cur_q.hi) < 32'(item_q.range_start)) ||
                        (32'(cur_q.lo) > 32'(item_q.range_end));
    sts_o.stack_empty = (sp_q == '0);
    sts_o.stack_full  = (sp_q == SP_BITS'(STK_DEPTH));
    sts_o.out_blocked = out_valid_q && out_stall_i;
  end

  // walk position and running min / max
  always_comb begin
    cur_d     = cur_q;
    acc_min_d = acc_min_q;
    acc_max_d = acc_max_q;
    if (cmd_i.load) begin
      cur_d     = '{node: '0, lo: '0, hi: hi_root};
      acc_min_d = VAL_MAX;
      acc_max_d = VAL_MIN;
    end else if (cmd_i.desc_step) begin
      if (32'(item_q.position) <= 32'(mid)) begin
        cur_d = '{node: lchild, lo: cur_q.lo, hi: mid};
      end else begin
        cur_d = '{node: rchild, lo: mid + IDX_BITS'(1), hi: cur_q.hi};
      end
    end else if (cmd_i.leaf_write) begin
      acc_min_d = item_q.new_value;
      acc_max_d = item_q.new_value;
    end else if (cmd_i.asc_write) begin
      cur_d.node = parent;
      acc_min_d  = fold_min;
      acc_max_d  = fold_max;
    end else if (cmd_i.q_split) begin
      cur_d = '{node: lchild, lo: cur_q.lo, hi: mid};
    end else if (cmd_i.q_pop || cmd_i.q_acc) begin
      if (cmd_i.q_acc) begin
        acc_min_d = fold_min;
        acc_max_d = fold_max;
      end
      if (cmd_i.q_pop) cur_d = stk_q[sp_dec[SPI_BITS-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    acc_min_q <= acc_min_d;
    acc_max_q <= acc_max_d;
    if (cmd_i.load) item_q <= in_data_i;
    // pending right halves of split query nodes
    if (cmd_i.q_split) begin
      stk_q[sp_q[SPI_BITS-1:0]] <= '{node: rchild, lo: mid + IDX_BITS'(1), hi: cur_q.hi};
    end
  end

  // control registers: stack pointer, clear sweep, output flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        sp_q <= '0;
      end else if (cmd_i.q_split) begin
        sp_q <= sp_q + SP_BITS'(1);
      end else if (cmd_i.q_pop) begin
        sp_q <= sp_dec;
      end
      if (cmd_i.clr_step) clr_q <= clr_q + NODE_BITS'(1);
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (!sts_o.q_ok) begin
        out_q <= '{status: STATUS_BAD, range_min: VAL_NEG_ONE, range_max: VAL_NEG_ONE};
      end else if (cmd_i.q_acc) begin
        out_q <= '{status: STATUS_OK, range_min: fold_min, range_max: fold_max};
      end else begin
        out_q <= '{status: STATUS_OK, range_min: acc_min_q, range_max: acc_max_q};
      end
    end
  end

  // node memory ports
  always_comb begin
    we     = cmd_i.clr_step || cmd_i.leaf_write || cmd_i.asc_write;
    waddr  = cur_q.node;
    wd_min = item_q.new_value;
    wd_max = item_q.new_value;
    if (cmd_i.clr_step) begin
      waddr  = clr_q;
      wd_min = VAL_MAX;
      wd_max = VAL_MIN;
    end else if (cmd_i.asc_write) begin
      waddr  = parent;
      wd_min = fold_min;
      wd_max = fold_max;
    end
    raddr = cmd_i.sib_read ? sibling : cur_q.node;
  end

  rmmt_ram #(.WIDTH(VALUE_BITS), .DEPTH(TREE_SLOTS)) u_min_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wd_min),
    .raddr_i (raddr),
    .rdata_o (rd_min)
  );

  rmmt_ram #(.WIDTH(VALUE_BITS), .DEPTH(TREE_SLOTS)) u_max_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wd_max),
    .raddr_i (raddr),
    .rdata_o (rd_max)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/range_min_max_tree_top.sv =====
// Channel   Dir  Handshake               Payload
// in        in   in_valid_i / in_stall_o  in_data_i   (action, position, value, range)
// out       out  out_valid_o / out_stall_i out_data_o (status, range_min, range_max)
// cfg       in   cfg_we_i                 cfg_wdata_i (entries_in_use)
//
// One request at a time. Update: accept, decode, descend one level a cycle to a leaf D
// levels below the root, leaf write, then a sibling read and a parent write per level
// on the way back up. Query: accept, decode, a visit of each node walked and a read of
// each covered node. An ignored update or invalid query ends after accept and decode.
// After reset a clearing pass writes the sentinels into all 4*MAX_ENTRIES node slots
// with input stalled. A finished query waits in the output register; the next request is taken while it is stalled.
`default_nettype none
`include "range_min_max_tree_top_macros.svh"
module range_min_max_tree_top #(
  parameter int MAX_ENTRIES = rmmt_pkg::DEF_MAX_ENTRIES
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire rmmt_pkg::in_item_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output rmmt_pkg::out_item_t                out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [rmmt_pkg::CFG_BITS-1:0] cfg_wdata_i
);
  import rmmt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rmmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  rmmt_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // a new result never lands on one still waiting
  `RMMT_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, cmd.out_load, !(out_valid_o && out_stall_i), "result overwritten")
  // split never overflows the frame stack
  `RMMT_ASSERT_NOW(a_stack_room, clk_i, rst_ni, cmd.q_split, !sts.stack_full, "query stack overflow")
  // a loaded result is presented next cycle
  `RMMT_ASSERT_NEXT(a_out_shown, clk_i, rst_ni, cmd.out_load, out_valid_o, "result not presented")

endmodule
`default_nettype wire

// ===== tb/range_min_max_tree_top_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
module range_min_max_tree_top_test;
  import rmmt_pkg::*;

  localparam int MAXN  = DEF_MAX_ENTRIES;
  localparam int SLOTS = 4 * MAXN;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  range_min_max_tree_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mirror of the tree contents and the active entry count
  logic signed [VALUE_BITS-1:0] tree_lo [SLOTS];
  logic signed [VALUE_BITS-1:0] tree_hi [SLOTS];
  int unsigned live_entries = MAXN;
  logic signed [VALUE_BITS-1:0] span_lo, span_hi;

  in_item_t  pending_reqs[$];
  out_item_t expected_answers[$];
  int errors = 0;
  int n_updates = 0, n_queries = 0, n_bad_queries = 0, n_checked = 0;

  function automatic void tree_store(int node, int lo, int hi, int pos,
                                     logic signed [VALUE_BITS-1:0] val);
    int mid;
    if (node >= SLOTS) return;
    if (lo == hi) begin
      tree_lo[node] = val;
      tree_hi[node] = val;
      return;
    end
    mid = lo + (hi - lo) / 2;
    if (pos <= mid) tree_store(2 * node + 1, lo, mid, pos, val);
    else tree_store(2 * node + 2, mid + 1, hi, pos, val);
    if (2 * node + 2 < SLOTS) begin
      tree_lo[node] = (tree_lo[2*node+1] < tree_lo[2*node+2]) ?
                      tree_lo[2*node+1] : tree_lo[2*node+2];
      tree_hi[node] = (tree_hi[2*node+1] > tree_hi[2*node+2]) ?
                      tree_hi[2*node+1] : tree_hi[2*node+2];
    end
  endfunction

  // folds covering nodes into span_lo / span_hi
  function automatic void tree_gather(int node, int lo, int hi, int qs, int qe);
    int mid;
    if (node >= SLOTS) return;
    if (qs <= lo && qe >= hi) begin
      if (tree_lo[node] < span_lo) span_lo = tree_lo[node];
      if (tree_hi[node] > span_hi) span_hi = tree_hi[node];
      return;
    end
    if (hi < qs || lo > qe || lo == hi) return;
    mid = lo + (hi - lo) / 2;
    tree_gather(2 * node + 1, lo, mid, qs, qe);
    tree_gather(2 * node + 2, mid + 1, hi, qs, qe);
  endfunction

  // applies one accepted request, queues the answer for queries
  function automatic void apply_request(in_item_t req);
    out_item_t ans;
    if (req.action == ACT_UPDATE) begin
      n_updates++;
      if (req.position < live_entries)
        tree_store(0, 0, live_entries - 1, req.position, req.new_value);
    end else begin
      n_queries++;
      if (req.range_start > req.range_end || req.range_end >= live_entries) begin
        n_bad_queries++;
        ans.status = STATUS_BAD;
        ans.range_min = VAL_NEG_ONE;
        ans.range_max = VAL_NEG_ONE;
      end else begin
        span_lo = VAL_MAX;
        span_hi = VAL_MIN;
        tree_gather(0, 0, live_entries - 1, req.range_start, req.range_end);
        ans.status = STATUS_OK;
        ans.range_min = span_lo;
        ans.range_max = span_hi;
      end
      expected_answers.push_back(ans);
    end
  endfunction

  // sender: bursts of requests separated by random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    logic nv;
    nv = in_valid;
    if (in_valid && !in_stall) begin
      apply_request(in_data);
      nv = 1'b0;
    end
    if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() > 0) begin
        in_data <= pending_reqs.pop_front();
        nv = 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end
      end
    end
    in_valid <= nv;
  end

  // receiver: stall pattern drawn at random from four modes; long hold on request
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0, stall_mode = 0, mode_age = 0;
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left = 600;
    end
    if (mode_age == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_age = 64;
    end
    mode_age--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 1);
        2: out_stall <= ($urandom_range(0, 7) != 0);
        default: out_stall <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result: status=%0d min=%0d max=%0d",
               out_data.status, out_data.range_min, out_data.range_max);
        errors++;
      end else begin
        want = expected_answers.pop_front();
        n_checked++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.range_min !== want.range_min) begin
          $error("range_min: expected %0d, got %0d", want.range_min, out_data.range_min);
          errors++;
        end
        if (out_data.range_max !== want.range_max) begin
          $error("range_max: expected %0d, got %0d", want.range_max, out_data.range_max);
          errors++;
        end
      end
    end
  end

  function automatic in_item_t mk_update(int pos, logic signed [VALUE_BITS-1:0] val);
    in_item_t r;
    r = '0;
    r.action = ACT_UPDATE;
    r.position = POS_BITS'(pos);
    r.new_value = val;
    r.range_start = POS_BITS'($urandom());
    r.range_end = POS_BITS'($urandom());
    return r;
  endfunction

  function automatic in_item_t mk_query(int qs, int qe);
    in_item_t r;
    r = '0;
    r.action = ACT_QUERY;
    r.position = POS_BITS'($urandom());
    r.new_value = VALUE_BITS'($urandom());
    r.range_start = POS_BITS'(qs);
    r.range_end = POS_BITS'(qe);
    return r;
  endfunction

  // drain everything, then let a trailing update finish
  task automatic wait_idle();
    do @(posedge clk); while (pending_reqs.size() > 0 || in_valid ||
                             expected_answers.size() > 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_entries(int val);
    int unsigned eff;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_BITS'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    eff = val & 11'h7FF;
    if (eff == 0) eff = 1;
    if (eff > MAXN) eff = MAXN;
    live_entries = eff;
  endtask

  function automatic logic signed [VALUE_BITS-1:0] rnd_value();
    case ($urandom_range(0, 5))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return $urandom_range(0, 20) - 10;
      default: return $urandom();
    endcase
  endfunction

  // mostly legal traffic with some out-of-range noise
  task automatic random_traffic(int count);
    int n, qs, qe;
    n = live_entries;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 4) begin
        if ($urandom_range(0, 9) == 0) pending_reqs.push_back(mk_update($urandom_range(0, 1023), rnd_value()));
        else pending_reqs.push_back(mk_update($urandom_range(0, n - 1), rnd_value()));
      end else begin
        case ($urandom_range(0, 9))
          0: pending_reqs.push_back(mk_query($urandom_range(0, 1023), $urandom_range(0, 1023)));
          1: pending_reqs.push_back(mk_query(0, n - 1));
          default: begin
            qs = $urandom_range(0, n - 1);
            qe = ($urandom_range(0, 1) == 1) ? $urandom_range(qs, n - 1) :
                 ((qs + $urandom_range(0, 8) < n) ? qs + $urandom_range(0, 8) : n - 1);
            pending_reqs.push_back(mk_query(qs, qe));
          end
        endcase
      end
    end
  endtask

  initial begin
    int settings[6];
    settings = '{1, 0, 2047, 7, 100, 513};
    // mirror starts at the empty sentinels, as the block does after clearing
    foreach (tree_lo[k]) begin
      tree_lo[k] = VAL_MAX;
      tree_hi[k] = VAL_MIN;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (in_stall);
    write_entries(MAXN);

    // directed: unwritten tree, extremes, bad ranges, ignored updates
    pending_reqs.push_back(mk_query(0, MAXN - 1));
    pending_reqs.push_back(mk_query(5, 5));
    pending_reqs.push_back(mk_update(0, VAL_MIN));
    pending_reqs.push_back(mk_update(1023, VAL_MAX));
    pending_reqs.push_back(mk_update(512, 0));
    pending_reqs.push_back(mk_update(511, VAL_NEG_ONE));
    pending_reqs.push_back(mk_query(0, 1023));
    pending_reqs.push_back(mk_query(1023, 1023));
    pending_reqs.push_back(mk_query(0, 0));
    pending_reqs.push_back(mk_query(1, 1022));
    pending_reqs.push_back(mk_query(511, 512));
    pending_reqs.push_back(mk_query(10, 9));
    pending_reqs.push_back(mk_query(1023, 0));
    pending_reqs.push_back(mk_update(0, 32'sh5555_AAAA));
    pending_reqs.push_back(mk_update(1023, 32'shAAAA_5555));
    pending_reqs.push_back(mk_query(0, 1023));
    wait_idle();
    write_entries(3);
    pending_reqs.push_back(mk_update(3, 77));
    pending_reqs.push_back(mk_update(1023, 77));
    pending_reqs.push_back(mk_query(0, 2));
    pending_reqs.push_back(mk_query(0, 3));
    pending_reqs.push_back(mk_query(2, 1023));
    wait_idle();

    // random phases across register settings, layout kept between them
    write_entries(MAXN);
    random_traffic(150);
    hold_req = ~hold_req;
    random_traffic(60);
    wait_idle();
    foreach (settings[k]) begin
      write_entries(settings[k]);
      random_traffic(50);
      wait_idle();
    end

    $display("covered %0d updates, %0d queries (%0d invalid), %0d results checked",
             n_updates, n_queries, n_bad_queries, n_checked);
    $display("entry counts from 1 to %0d, including out-of-range register values", MAXN);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/rmmt_pkg.sv
rtl/rmmt_ram.sv
rtl/rmmt_ctrl.sv
rtl/rmmt_dp.sv
rtl/range_min_max_tree_top.sv
tb/range_min_max_tree_top_test.sv
